// ----- rtl/core/ssq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants of the stable sorted priority queue
// Entry layout, command bundle, status codes and widths.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = 5;
    localparam int VAL_W   = 32;
    localparam int PRI_W   = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] prio;
    } entry_t;

    // Broadcast to every cell of the chain in the cycle a word is taken.
    typedef struct packed {
        logic   ins;
        logic   deq;
        entry_t item;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/ssq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_cell: one compare-and-shift slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's entry; on removal it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module ssq_cell
    import ssq_pkg::*;
(
    input  wire logic   clk,
    input  wire cmd_t   cmd,
    input  wire logic   occupied,
    input  wire logic   left_held,
    input  wire entry_t left_entry,
    input  wire entry_t right_entry,
    output logic        held,
    output entry_t      entry,
    output entry_t      entry_next
);

    entry_t entry_reg;

    // An entry of equal priority stays ahead of the new one, which keeps ties
    // in arrival order.
    assign held  = occupied && (entry_reg.prio <= cmd.item.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (held)
                entry_next = entry_reg;
            else if (left_held)
                entry_next = cmd.item;
            else
                entry_next = left_entry;
        end
        else if (cmd.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/stable_sorted_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: bounded priority queue with stable ties
// A chain of compare-and-shift cells kept sorted by priority, front at cell 0.
// ----------------------------------------------------------------------------
// The queue takes one word per clock cycle and its result word appears in the
// output register in the cycle after the word is taken. Every cell compares its
// priority with the new one and shifts in the same cycle, so the rate is set
// by that single compare-and-select across the chain; taking a new word
// only waits when the output register holds a result that has not been taken.
// Lower priority numbers leave first, equal priorities leave in arrival order.
// An enqueue on a full queue is dropped with status full, a dequeue on an
// empty queue reports underflow; the queue is unchanged in both cases.
module stable_sorted_priority_queue
    import ssq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // item_value[31:0], item_priority[63:32]
    input  wire logic        s_tuser,   // func[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // status[1:0], front_valid[2],
                                        // front_value[34:3], entry_count[39:35]
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    logic [39:0]      out_data_reg;

    logic   take;
    logic   full, empty;
    cmd_t   cmd;
    logic [1:0] status;

    logic   held       [DEPTH];
    logic   occupied   [DEPTH];
    logic   left_held  [DEPTH];
    entry_t entry      [DEPTH];
    entry_t entry_next [DEPTH];
    entry_t left_entry [DEPTH];
    entry_t right_entry[DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    assign cmd.ins        = take && (s_tuser == FUNC_ENQ) && !full;
    assign cmd.deq        = take && (s_tuser == FUNC_DEQ) && !empty;
    assign cmd.item.value = s_tdata[31:0];
    assign cmd.item.prio  = s_tdata[63:32];

    always_comb
    begin
        count_next = count_reg;
        status     = ST_OK;
        if (s_tuser == FUNC_ENQ)
        begin
            if (full)
                status = ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            if (empty)
                status = ST_UNDERFLOW;
            else
                count_next = count_reg - CNT_W'(1);
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign occupied[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign left_held[i]  = 1'b1;
                assign left_entry[i] = cmd.item;
            end
            else
            begin : g_mid
                assign left_held[i]  = held[i-1];
                assign left_entry[i] = entry[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_entry[i] = entry[i];
            end
            else
            begin : g_inner
                assign right_entry[i] = entry[i+1];
            end

            ssq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occupied[i]),
                .left_held   (left_held[i]),
                .left_entry  (left_entry[i]),
                .right_entry (right_entry[i]),
                .held        (held[i]),
                .entry       (entry[i]),
                .entry_next  (entry_next[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The front of the result is what cell 0 holds once this word is applied.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg[1:0]   <= status;
            out_data_reg[2]     <= (count_next != '0);
            out_data_reg[34:3]  <= (count_next != '0) ? entry_next[0].value : '0;
            out_data_reg[39:35] <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s_tuser == FUNC_ENQ && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted enqueue did not add an entry");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s_tuser == FUNC_ENQ && full) |=> (m_tvalid && m_tdata[1:0] == ST_FULL
            && m_tdata[39:35] == CNT_W'(DEPTH)))
        else $error("enqueue on full queue not flagged");

    a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2] == (m_tdata[39:35] != '0)))
        else $error("front_valid disagrees with entry count");

endmodule
`default_nettype wire
